FILE: hw/rtl/agr_pkg.sv
// ----------------------------------------------------------------------------
// ADC sample glitch repair: shared types and constants
// Beat formats for both channels, the decoded sample passed from the front
// to the back, register indexes and the window fill states.
// ----------------------------------------------------------------------------
package agr_pkg;

  // Configuration register indexes.
  localparam logic REG_JUMP_THRESHOLD     = 1'b0;
  localparam logic REG_NEIGHBOR_THRESHOLD = 1'b1;

  // Reset values of the thresholds.
  localparam logic [15:0] JUMP_THRESHOLD_RESET     = 16'd8192;
  localparam logic [15:0] NEIGHBOR_THRESHOLD_RESET = 16'd8192;

  // Sample decoding constants.
  localparam logic [12:0] CODE_CENTRE  = 13'd2048;
  localparam int          SAMPLE_SHIFT = 4;
  localparam int          OTR_BIT      = 30;

  // The over-range tally saturates at its widest value.
  localparam logic [14:0] TALLY_MAX = 15'h7FFF;

  // One input beat.
  typedef struct packed {
    logic [31:0] gpio_word;
    logic        last;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               over_range;
    logic               repaired;
    logic [14:0]        block_overrange_count;
    logic [31:0]        glitch_total;
    logic               end_of_block;
  } result_t;

  // Decoded sample handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               over_range;
    logic               last;
  } cmd_t;

  // How much of the three-sample window is occupied.
  typedef enum logic [1:0] {
    FILL_EMPTY,
    FILL_FIRST,
    FILL_FULL
  } fill_t;

endpackage

FILE: hw/rtl/adc_sample_glitch_repair.sv
// ----------------------------------------------------------------------------
// ADC sample glitch repair
// Decodes GPIO snapshots into centred ADC samples, repairs isolated glitches
// over a three-sample window and counts over-range samples and repairs.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Beat                 Notes
//  input     push / full      item  (item_t)       one GPIO snapshot
//  result    empty / pop      result (result_t)    zero, one or two beats per item
//  config    cfg_we           cfg_index, cfg_data  no wait, no read-back
//
//  One item is taken per cycle while full is low. Each sample is
//  registered in the front queue, then the back end writes its beats
//  into the result queue. The back end takes a sample only when the
//  result queue has room for two beats, so a stalled pop fills the
//  result queue and then the front queue before full rises.
//  Synchronous reset empties both queues and clears window and tallies.
// ----------------------------------------------------------------------------
module adc_sample_glitch_repair #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  agr_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output agr_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  logic          cmd_valid;
  logic          cmd_take;
  agr_pkg::cmd_t cmd;
  logic [15:0]   jump_threshold;
  logic [15:0]   neighbor_threshold;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold     <= agr_pkg::JUMP_THRESHOLD_RESET;
      neighbor_threshold <= agr_pkg::NEIGHBOR_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        agr_pkg::REG_JUMP_THRESHOLD:     jump_threshold     <= cfg_data;
        agr_pkg::REG_NEIGHBOR_THRESHOLD: neighbor_threshold <= cfg_data;
        default:                         jump_threshold     <= jump_threshold;
      endcase
    end
  end

  agr_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  agr_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_take           (cmd_take),
    .jump_threshold     (jump_threshold),
    .neighbor_threshold (neighbor_threshold),
    .empty              (empty),
    .pop                (pop),
    .result             (result)
  );

endmodule

FILE: hw/rtl/agr_front.sv
// ----------------------------------------------------------------------------
// ADC sample glitch repair: front end
// Accepts GPIO snapshots, gathers the scattered ADC pins into a centred
// sample and queues the decoded samples for the back end.
// ----------------------------------------------------------------------------
module agr_front #(
  parameter int CMD_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  agr_pkg::item_t item,
  output logic           cmd_valid,
  output agr_pkg::cmd_t  cmd,
  input  logic           cmd_take
);

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  // Word bit that feeds each code bit, code bit 0 first.
  localparam logic [4:0] CODE_SRC [0:11] = '{
    5'd17, 5'd8, 5'd10, 5'd12, 5'd14, 5'd24, 5'd15, 5'd13, 5'd11, 5'd9, 5'd7, 5'd16
  };

  agr_pkg::cmd_t     mem [CMD_DEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic [11:0]       code;
  logic signed [12:0] centred;
  agr_pkg::cmd_t     decoded;
  logic              do_push;
  logic              do_pop;

  // Gather the data pins and centre the code.
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      code[k] = item.gpio_word[CODE_SRC[k]];
    end
    centred            = $signed({1'b0, code}) - $signed(agr_pkg::CODE_CENTRE);
    decoded.sample     = {centred[11:0], {agr_pkg::SAMPLE_SHIFT{1'b0}}};
    decoded.over_range = item.gpio_word[agr_pkg::OTR_BIT];
    decoded.last       = item.last;
  end

  assign full      = (count == CW'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= decoded;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(CMD_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(CMD_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/agr_back.sv
// ----------------------------------------------------------------------------
// ADC sample glitch repair: back end
// Runs the three-sample repair window and the tallies on each decoded
// sample and writes up to two result beats per sample into a result queue.
// ----------------------------------------------------------------------------
module agr_back #(
  parameter int RES_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  agr_pkg::cmd_t    cmd,
  output logic             cmd_take,
  input  logic [15:0]      jump_threshold,
  input  logic [15:0]      neighbor_threshold,
  output logic             empty,
  input  logic             pop,
  output agr_pkg::result_t result
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  agr_pkg::result_t   mem [RES_DEPTH];
  logic [PW-1:0]      wptr;
  logic [PW-1:0]      wptr_inc;
  logic [PW-1:0]      wptr_b;
  logic [PW-1:0]      rptr;
  logic [CW-1:0]      count;
  logic [1:0]         n_write;
  logic               do_pop;

  // Window and tally state.
  agr_pkg::fill_t     fill;
  agr_pkg::fill_t     fill_next;
  logic signed [15:0] prior_output;
  logic signed [15:0] prior_output_next;
  logic signed [15:0] held_sample;
  logic signed [15:0] held_sample_next;
  logic               held_over_range;
  logic               held_over_range_next;
  logic [14:0]        overrange_tally;
  logic [14:0]        overrange_tally_next;
  logic [31:0]        repair_tally;
  logic [31:0]        repair_tally_next;

  // Window arithmetic.
  logic signed [16:0] d_prior;
  logic signed [16:0] d_next;
  logic signed [16:0] d_nbr;
  logic [16:0]        a_prior;
  logic [16:0]        a_next;
  logic [16:0]        a_nbr;
  logic signed [16:0] nbr_sum;
  logic signed [16:0] nbr_sum_adj;
  logic signed [16:0] nbr_mean;
  logic               repair;
  logic               emit_held;
  logic               emit_last;
  logic [14:0]        tally_now;
  logic signed [15:0] held_out;
  agr_pkg::result_t   res_a;
  agr_pkg::result_t   res_b;

  // A sample is taken only when the queue has room for both of its beats.
  assign cmd_take = cmd_valid && (count <= CW'(RES_DEPTH - 2));

  // Jumps to both neighbours and the neighbour spread.
  always_comb begin
    d_prior = 17'(held_sample) - 17'(prior_output);
    d_next  = 17'(held_sample) - 17'(cmd.sample);
    d_nbr   = 17'(prior_output) - 17'(cmd.sample);
    a_prior = d_prior[16] ? 17'(-d_prior) : 17'(d_prior);
    a_next  = d_next[16]  ? 17'(-d_next)  : 17'(d_next);
    a_nbr   = d_nbr[16]   ? 17'(-d_nbr)   : 17'(d_nbr);
    // Mean of the neighbours, truncated toward zero.
    nbr_sum     = 17'(prior_output) + 17'(cmd.sample);
    nbr_sum_adj = (nbr_sum[16] && nbr_sum[0]) ? nbr_sum + 17'sd1 : nbr_sum;
    nbr_mean    = nbr_sum_adj >>> 1;
    repair = (fill == agr_pkg::FILL_FULL) && !held_over_range &&
             (a_prior > {1'b0, jump_threshold}) &&
             (a_next  > {1'b0, jump_threshold}) &&
             (a_nbr   < {1'b0, neighbor_threshold});
    held_out = repair ? nbr_mean[15:0] : held_sample;
  end

  // Window state update and the beats for this sample.
  always_comb begin
    emit_held = (fill != agr_pkg::FILL_EMPTY);
    emit_last = cmd.last;
    tally_now = (cmd.over_range && (overrange_tally != agr_pkg::TALLY_MAX)) ?
                overrange_tally + 15'd1 : overrange_tally;

    fill_next            = fill;
    prior_output_next    = prior_output;
    held_sample_next     = held_sample;
    held_over_range_next = held_over_range;
    overrange_tally_next = overrange_tally;
    repair_tally_next    = repair_tally;

    if (cmd_take) begin
      overrange_tally_next = tally_now;
      if (emit_held) begin
        prior_output_next = held_out;
        repair_tally_next = repair_tally + {31'd0, repair};
      end
      if (emit_last) begin
        prior_output_next    = cmd.sample;
        overrange_tally_next = '0;
        fill_next            = agr_pkg::FILL_EMPTY;
        held_sample_next     = '0;
        held_over_range_next = 1'b0;
      end else begin
        held_sample_next     = cmd.sample;
        held_over_range_next = cmd.over_range;
        case (fill)
          agr_pkg::FILL_EMPTY: fill_next = agr_pkg::FILL_FIRST;
          default:             fill_next = agr_pkg::FILL_FULL;
        endcase
      end
    end

    res_a.sample                = held_out;
    res_a.over_range            = held_over_range;
    res_a.repaired              = repair;
    res_a.block_overrange_count = tally_now;
    res_a.glitch_total          = repair_tally + {31'd0, repair};
    res_a.end_of_block          = 1'b0;

    res_b.sample                = cmd.sample;
    res_b.over_range            = cmd.over_range;
    res_b.repaired              = 1'b0;
    res_b.block_overrange_count = tally_now;
    res_b.glitch_total          = res_a.glitch_total;
    res_b.end_of_block          = 1'b1;
  end

  // Window state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= agr_pkg::FILL_EMPTY;
      prior_output    <= '0;
      held_sample     <= '0;
      held_over_range <= 1'b0;
      overrange_tally <= '0;
      repair_tally    <= '0;
    end else begin
      fill            <= fill_next;
      prior_output    <= prior_output_next;
      held_sample     <= held_sample_next;
      held_over_range <= held_over_range_next;
      overrange_tally <= overrange_tally_next;
      repair_tally    <= repair_tally_next;
    end
  end

  // Result queue: the held beat goes first, the final beat of a block after it.
  assign wptr_inc = (wptr == PW'(RES_DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign wptr_b   = emit_held ? wptr_inc : wptr;
  assign n_write  = cmd_take ? ({1'b0, emit_held} + {1'b0, emit_last}) : 2'd0;
  assign empty    = (count == '0);
  assign result   = mem[rptr];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (cmd_take && emit_held) begin
      mem[wptr] <= res_a;
    end
    if (cmd_take && emit_last) begin
      mem[wptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      case (n_write)
        2'd1:    wptr <= wptr_inc;
        2'd2:    wptr <= (wptr_inc == PW'(RES_DEPTH - 1)) ? '0 : wptr_inc + 1'b1;
        default: wptr <= wptr;
      endcase
      if (do_pop) begin
        rptr <= (rptr == PW'(RES_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(n_write) - CW'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/agr_checker.sv
// ----------------------------------------------------------------------------
// ADC sample glitch repair: port checker
// Watches the top level's ports for properties of the repair window and of
// the running tallies.
// ----------------------------------------------------------------------------
module agr_port_checks (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input agr_pkg::result_t result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // An over-range sample is never repaired.
  a_no_repair_otr: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.repaired) |-> !result.over_range)
    else $error("over-range sample repaired");

  // The final sample of a block passes unchanged.
  a_eob_unrepaired: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.end_of_block) |-> !result.repaired)
    else $error("final sample of block repaired");

  // Each beat adds at most one repair to the total.
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> (empty ||
      result.glitch_total == $past(result.glitch_total) ||
      result.glitch_total == $past(result.glitch_total) + 32'd1))
    else $error("glitch total jumped");

  // After a block ends, the over-range count starts again from zero.
  a_tally_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && result.end_of_block) |=>
      (empty || result.block_overrange_count <= 15'd2))
    else $error("over-range count not restarted");

endmodule

bind adc_sample_glitch_repair agr_port_checks u_agr_port_checks (.*);
